// ===== rtl/core/heading_throttle_modulator_macros.svh =====
// Assertion macros for the heading throttle modulator RTL.
// Used by the modules under rtl/core; no other dependencies.
`ifndef HEADING_THROTTLE_MODULATOR_MACROS_SVH
`define HEADING_THROTTLE_MODULATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge of clk, off while reset is held.
`define HTM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define HTM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HTM_ASSERT(label, prop, msg)
`define HTM_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/core/htm_pkg.sv =====
// Package for the heading throttle modulator: default sizes, brake constants
// and the elaboration-time generator for the quarter-wave sine table.
// No dependencies.
`default_nettype none

package htm_pkg;

  localparam int unsigned ANGLE_BITS_DEF         = 16;
  localparam int unsigned LEVEL_BITS_DEF         = 16;
  localparam int unsigned SINE_TABLE_ENTRIES_DEF = 1024;

  // Quarter turn in radians, Q2.30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Brake is round(0.15 * gain), formed as (3 * gain + 10) / 20.
  localparam int unsigned BRAKE_NUM  = 3;
  localparam int unsigned BRAKE_BIAS = 10;
  localparam int unsigned BRAKE_DEN  = 20;

  // Factorial ratios between successive odd Taylor terms of the sine.
  localparam longint unsigned TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // One table entry from its angle in Q2.30, scaled to lvl fraction bits.
  function automatic longint unsigned sine_entry(input longint unsigned x, input int lvl);
    longint unsigned t;
    longint          sum;
    longint unsigned mag;
    t   = x;
    sum = longint'(x);
    for (int n = 0; n < 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n];
      if ((n & 1) == 0) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = longint'(unsigned'(sum));
    return ((mag << lvl) + (64'd1 << 29)) >> 30;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/heading_throttle_modulator.sv =====
// A beat accepted at the input moves through the s1, s2 and output registers in
// turn; a stall on the output can hold it in a stage.
// Throughput is one beat per cycle; stages hold only while the output is
// stalled, and the input is stalled only when all three stages are full.
// Reset is synchronous and active low; it empties the pipeline and clears
// square_mode to sinusoidal. The sine table is a constant ROM, no fill pass.
`default_nettype none

`include "heading_throttle_modulator_macros.svh"

module heading_throttle_modulator #(
  parameter int unsigned ANGLE_BITS         = htm_pkg::ANGLE_BITS_DEF,
  parameter int unsigned LEVEL_BITS         = htm_pkg::LEVEL_BITS_DEF,
  parameter int unsigned SINE_TABLE_ENTRIES = htm_pkg::SINE_TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [ANGLE_BITS-1:0] in_heading,
  input  wire logic [ANGLE_BITS-1:0] in_direction,
  input  wire logic [LEVEL_BITS-1:0] in_base_level,
  input  wire logic [LEVEL_BITS-1:0] in_drift_gain,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [LEVEL_BITS-1:0]      out_throttle_a,
  output logic [LEVEL_BITS-1:0]      out_throttle_b
);

  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned POS_W  = ANGLE_BITS - 2;
  localparam int unsigned PROD_W = POS_W + IDX_W;
  localparam int unsigned SINE_W = LEVEL_BITS + 1;
  localparam int unsigned MAG_W  = LEVEL_BITS + SINE_W;

  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
  localparam logic [ANGLE_BITS-1:0] HALF    = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [IDX_W-1:0]      N_IDX   = IDX_W'(SINE_TABLE_ENTRIES);

  localparam int unsigned BX_W        = LEVEL_BITS + 2;
  localparam int unsigned BRAKE_SHIFT = BX_W + 5;
  localparam int unsigned BRAKE_MUL_W = BRAKE_SHIFT - 4;
  localparam int unsigned BP_W        = BX_W + BRAKE_MUL_W;
  localparam logic [BRAKE_MUL_W-1:0] BRAKE_MUL = BRAKE_MUL_W'(
    ((64'd1 << BRAKE_SHIFT) + htm_pkg::BRAKE_DEN - 1) / htm_pkg::BRAKE_DEN);

  // Quarter-wave sine ROM, entries 0 through SINE_TABLE_ENTRIES inclusive.
  logic [SINE_W-1:0] sine_rom [SINE_TABLE_ENTRIES + 1];

  for (genvar gk = 0; gk <= SINE_TABLE_ENTRIES; gk++) begin : g_rom
    localparam longint unsigned XQ =
      (longint'(gk) * htm_pkg::HALF_PI_Q30) / SINE_TABLE_ENTRIES;
    assign sine_rom[gk] = SINE_W'(htm_pkg::sine_entry(XQ, LEVEL_BITS));
  end

  logic cfg_square_mode_r;

  logic                  s1_vld_r;
  logic [ANGLE_BITS-1:0] s1_heading_r;
  logic [ANGLE_BITS-1:0] s1_direction_r;
  logic [LEVEL_BITS-1:0] s1_base_r;
  logic [LEVEL_BITS-1:0] s1_gain_r;

  logic                  s2_vld_r;
  logic [SINE_W-1:0]     s2_sine_r;
  logic                  s2_neg_r;
  logic                  s2_square_r;
  logic                  s2_a_boost_r;
  logic [LEVEL_BITS-1:0] s2_brake_r;
  logic [LEVEL_BITS-1:0] s2_base_r;
  logic [LEVEL_BITS-1:0] s2_gain_r;

  logic                  out_valid_r;
  logic [LEVEL_BITS-1:0] throttle_a_r;
  logic [LEVEL_BITS-1:0] throttle_b_r;

  logic s3_en;
  logic s2_en;
  logic s1_en;

  logic [ANGLE_BITS-1:0] angle_diff;
  logic [ANGLE_BITS-1:0] split_diff;
  logic [PROD_W-1:0]     idx_prod;
  logic [IDX_W-1:0]      idx_fine;
  logic [IDX_W-1:0]      rom_idx;
  logic [BX_W-1:0]       brake_x;
  logic [BP_W-1:0]       brake_prod;
  logic [LEVEL_BITS-1:0] s2_brake_nxt;

  logic [MAG_W-1:0]      mag_prod;
  logic [LEVEL_BITS-1:0] mag;
  logic [LEVEL_BITS-1:0] up_amt;
  logic [LEVEL_BITS-1:0] down_amt;
  logic                  swap;
  logic [LEVEL_BITS:0]   sum_up;
  logic [LEVEL_BITS-1:0] level_up;
  logic [LEVEL_BITS-1:0] level_down;
  logic [LEVEL_BITS-1:0] throttle_a_nxt;
  logic [LEVEL_BITS-1:0] throttle_b_nxt;

  assign s3_en    = !out_valid_r || !out_stall;
  assign s2_en    = !s2_vld_r || s3_en;
  assign s1_en    = !s1_vld_r || s2_en;
  assign in_stall = !s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_square_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_square_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_heading_r   <= in_heading;
      s1_direction_r <= in_direction;
      s1_base_r      <= in_base_level;
      s1_gain_r      <= in_drift_gain;
    end
  end

  always_comb begin
    angle_diff   = s1_heading_r - s1_direction_r;
    split_diff   = angle_diff - QUARTER;
    idx_prod     = PROD_W'(angle_diff[POS_W-1:0]) * PROD_W'(SINE_TABLE_ENTRIES);
    idx_fine     = idx_prod[PROD_W-1:POS_W];
    rom_idx      = angle_diff[ANGLE_BITS-2] ? (N_IDX - idx_fine) : idx_fine;
    brake_x      = BX_W'(s1_gain_r) * BX_W'(htm_pkg::BRAKE_NUM)
                   + BX_W'(htm_pkg::BRAKE_BIAS);
    brake_prod   = BP_W'(brake_x) * BP_W'(BRAKE_MUL);
    s2_brake_nxt = LEVEL_BITS'(brake_prod >> BRAKE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_sine_r    <= sine_rom[rom_idx];
      s2_neg_r     <= angle_diff[ANGLE_BITS-1];
      s2_square_r  <= cfg_square_mode_r;
      s2_a_boost_r <= (split_diff <= HALF);
      s2_brake_r   <= s2_brake_nxt;
      s2_base_r    <= s1_base_r;
      s2_gain_r    <= s1_gain_r;
    end
  end

  always_comb begin
    mag_prod = MAG_W'(s2_gain_r) * MAG_W'(s2_sine_r)
               + (MAG_W'(1) << (LEVEL_BITS - 1));
    mag      = LEVEL_BITS'(mag_prod >> LEVEL_BITS);
    up_amt   = s2_square_r ? s2_gain_r : mag;
    down_amt = s2_square_r ? s2_brake_r : mag;
    swap     = s2_square_r ? !s2_a_boost_r : s2_neg_r;
    sum_up   = {1'b0, s2_base_r} + {1'b0, up_amt};
    level_up = sum_up[LEVEL_BITS] ? '1 : sum_up[LEVEL_BITS-1:0];
    level_down = (down_amt > s2_base_r) ? '0 : (s2_base_r - down_amt);
    throttle_a_nxt = swap ? level_down : level_up;
    throttle_b_nxt = swap ? level_up : level_down;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_en) begin
      out_valid_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en) begin
      throttle_a_r <= throttle_a_nxt;
      throttle_b_r <= throttle_b_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_throttle_a = throttle_a_r;
  assign out_throttle_b = throttle_b_r;

  `HTM_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")
  `HTM_ASSERT(a_stall_from_output, in_stall |-> out_stall, "input stalled without output stall")
  `HTM_ASSERT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid, "beat did not arrive after two cycles")
  `HTM_ASSERT(a_zero_gain, (s2_vld_r && s2_gain_r == '0) |-> (throttle_a_nxt == s2_base_r && throttle_b_nxt == s2_base_r), "zero gain changed base level")
  `HTM_ASSERT(a_one_side_up, s2_vld_r |-> (throttle_a_nxt >= s2_base_r || throttle_b_nxt >= s2_base_r), "both throttles below base level")

endmodule

`default_nettype wire
